@@ src/firlc_pkg.sv @@
`default_nettype none

package firlc_pkg;

    localparam int TAPS_DEF = 64;
    localparam int KIND_W   = 2;
    localparam int IDX_W    = 6;
    localparam int DATA_W   = 16;
    localparam int CNT_W    = 7;
    localparam int PROD_W   = 32;
    localparam int ACC_W    = 38;
    localparam int QDEPTH   = 4;

    localparam logic [CNT_W-1:0] TAP_COUNT_RST = 7'd29;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] op;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
    } t_cmd;

endpackage

`default_nettype wire

@@ src/firlc_if.sv @@
`default_nettype none

interface firlc_in_if;
    logic                                valid;
    logic                                ready;
    logic [firlc_pkg::KIND_W-1:0]        kind;
    logic [firlc_pkg::IDX_W-1:0]         tap_index;
    logic signed [firlc_pkg::DATA_W-1:0] coefficient;
    logic signed [firlc_pkg::DATA_W-1:0] sample;

    modport source (output valid, kind, tap_index, coefficient, sample, input ready);
    modport sink   (input valid, kind, tap_index, coefficient, sample, output ready);
endinterface

interface firlc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [firlc_pkg::ACC_W-1:0] result_value;
    logic                               last;

    modport source (output valid, result_value, last, input ready);
    modport sink   (input valid, result_value, last, output ready);
endinterface

interface firlc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [firlc_pkg::CNT_W-1:0]  tap_count;

    modport source (output valid, tap_count, input ready);
    modport sink   (input valid, tap_count, output ready);
endinterface

`default_nettype wire

@@ src/fir_linear_convolution.sv @@
// Streaming FIR filter giving the full linear convolution of a sample stream
// with a loaded impulse response (Q1.15 data, Q8.30 38-bit results).
// Channels: i_in takes beats of kind load coefficient, sample or flush;
// o_out gives result_value and last; i_cfg writes tap_count (taps in use).
// A sample gives one result; a flush gives tap_count results (0 acts as 1,
// more than TAPS as TAPS), last on the final one, then clears the history.
// Loads and kind 3 give nothing. Input beats go into a 4-entry command queue;
// the back end takes one command per cycle while o_out is not stalled, and a
// flush holds the head until its last result is issued. Throughput: one
// sample per cycle while o_out is not stalled. A result passes the queue,
// the multiply register and one register per level of the adder tree.
// When o_out is stalled the whole back pipeline holds; the queue still
// takes up to 4 beats before i_in.ready drops.
// Reset clears history, coefficients and the queue and sets tap_count to 29.
`default_nettype none

module fir_linear_convolution #(
    parameter int TAPS = firlc_pkg::TAPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    firlc_in_if.sink     i_in,
    firlc_cfg_if.sink    i_cfg,
    firlc_out_if.source  o_out
);
    import firlc_pkg::*;

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    firlc_front #(
        .TAPS (TAPS)
    ) u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    firlc_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    firlc_back #(
        .TAPS (TAPS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .i_cmd     (head_cmd),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

@@ src/firlc_front.sv @@
`default_nettype none

module firlc_front #(
    parameter int TAPS = firlc_pkg::TAPS_DEF
) (
    firlc_in_if.sink         i_in,
    input  logic             i_q_full,
    output logic             o_push,
    output firlc_pkg::t_cmd  o_cmd
);
    import firlc_pkg::*;

    logic keep;

    assign i_in.ready = !i_q_full;

    always_comb begin
        case (i_in.kind)
            KIND_LOAD:   keep = (CNT_W'(i_in.tap_index) < CNT_W'(TAPS));
            KIND_SAMPLE: keep = 1'b1;
            KIND_FLUSH:  keep = 1'b1;
            default:     keep = 1'b0;
        endcase
    end

    always_comb begin
        o_cmd.op   = i_in.kind;
        o_cmd.idx  = i_in.tap_index;
        o_cmd.data = (i_in.kind == KIND_LOAD) ? i_in.coefficient : i_in.sample;
    end

    assign o_push = i_in.valid && i_in.ready && keep;

endmodule

`default_nettype wire

@@ src/firlc_queue.sv @@
`default_nettype none

module firlc_queue #(
    parameter int DEPTH = firlc_pkg::QDEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  firlc_pkg::t_cmd  i_cmd,
    input  logic             i_pop,
    output firlc_pkg::t_cmd  o_cmd,
    output logic             o_full,
    output logic             o_empty
);
    import firlc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

@@ src/firlc_back.sv @@
`default_nettype none

module firlc_back #(
    parameter int TAPS = firlc_pkg::TAPS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    firlc_cfg_if.sink        i_cfg,
    input  firlc_pkg::t_cmd  i_cmd,
    input  logic             i_q_empty,
    output logic             o_pop,
    firlc_out_if.source      o_out
);
    import firlc_pkg::*;

    localparam int LVL    = $clog2(TAPS);
    localparam int LEAVES = 1 << LVL;

    logic [CNT_W-1:0]         r_tap_count;
    logic [CNT_W-1:0]         n_taps;
    logic [CNT_W-1:0]         r_fcnt;
    logic signed [DATA_W-1:0] r_hist   [TAPS];
    logic signed [DATA_W-1:0] r_coef   [TAPS];
    logic signed [DATA_W-1:0] sh_hist  [TAPS];
    logic signed [DATA_W-1:0] coef_eff [TAPS];
    logic signed [PROD_W-1:0] prod     [TAPS];
    logic [ACC_W-1:0]         r_node   [LVL+1][LEAVES];
    logic [LVL:0]             r_vld;
    logic [LVL:0]             r_lst;
    logic                     en;
    logic                     head;
    logic                     issue;
    logic                     flush_last;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        if (r_tap_count == '0) begin
            n_taps = CNT_W'(1);
        end else if (r_tap_count > CNT_W'(TAPS)) begin
            n_taps = CNT_W'(TAPS);
        end else begin
            n_taps = r_tap_count;
        end
    end

    assign en         = !r_vld[LVL] || o_out.ready;
    assign head       = en && !i_q_empty;
    assign flush_last = (i_cmd.op == KIND_FLUSH) && (r_fcnt == n_taps - CNT_W'(1));
    assign issue      = head && ((i_cmd.op == KIND_SAMPLE) || (i_cmd.op == KIND_FLUSH));
    assign o_pop      = head && ((i_cmd.op != KIND_FLUSH) || flush_last);

    always_comb begin
        sh_hist[0] = (i_cmd.op == KIND_SAMPLE) ? i_cmd.data : '0;
        for (int k = 1; k < TAPS; k++) begin
            sh_hist[k] = r_hist[k-1];
        end
        for (int k = 0; k < TAPS; k++) begin
            coef_eff[k] = (CNT_W'(k) < n_taps) ? r_coef[k] : '0;
            prod[k]     = coef_eff[k] * sh_hist[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RST;
        end else if (i_cfg.valid) begin
            r_tap_count <= i_cfg.tap_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS; k++) begin
                r_coef[k] <= '0;
            end
        end else if (head && (i_cmd.op == KIND_LOAD)) begin
            for (int k = 0; k < TAPS; k++) begin
                if (i_cmd.idx == IDX_W'(k)) begin
                    r_coef[k] <= i_cmd.data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS; k++) begin
                r_hist[k] <= '0;
            end
        end else if (issue) begin
            for (int k = 0; k < TAPS; k++) begin
                r_hist[k] <= flush_last ? '0 : sh_hist[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt <= '0;
        end else if (head && (i_cmd.op == KIND_FLUSH)) begin
            r_fcnt <= flush_last ? '0 : r_fcnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_lst <= '0;
        end else if (en) begin
            r_vld[0] <= issue;
            r_lst[0] <= issue && flush_last;
            for (int l = 1; l <= LVL; l++) begin
                r_vld[l] <= r_vld[l-1];
                r_lst[l] <= r_lst[l-1];
            end
        end
    end

    // adder tree, one register per level
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < TAPS; k++) begin
                r_node[0][k] <= {{(ACC_W-PROD_W){prod[k][PROD_W-1]}}, prod[k]};
            end
            for (int k = TAPS; k < LEAVES; k++) begin
                r_node[0][k] <= '0;
            end
            for (int l = 1; l <= LVL; l++) begin
                for (int i = 0; i < (LEAVES >> l); i++) begin
                    r_node[l][i] <= r_node[l-1][2*i] + r_node[l-1][2*i+1];
                end
            end
        end
    end

    assign o_out.valid        = r_vld[LVL];
    assign o_out.result_value = r_node[LVL][0];
    assign o_out.last         = r_lst[LVL];

    a_fcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt < n_taps) else $error("flush step count past tap count");
    a_hist_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && flush_last) |=> (r_hist[0] == '0) && (r_hist[TAPS-1] == '0))
        else $error("history not cleared after flush");
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lst[LVL] |-> r_vld[LVL]) else $error("last flag without valid beat");
    a_flush_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_cmd.op == KIND_FLUSH)) |=> r_lst[0])
        else $error("flush popped without marking last");

endmodule

`default_nettype wire
